>>> hdl/llib_pkg.sv
package llib_pkg;

    localparam logic [14:0] LONGEST_LINE = 15'd16511;
    localparam logic [14:0] SHORT_LINE_MAX = 15'd127;
    localparam logic [7:0]  NEWLINE = 8'd10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // result slots of one command, in delivery order
    localparam int SLOT_ERR  = 0;
    localparam int SLOT_HI   = 1;
    localparam int SLOT_LO   = 2;
    localparam int SLOT_C1   = 3;
    localparam int SLOT_C2   = 4;
    localparam int SLOT_TERM = 5;
    localparam int NSLOTS    = 6;

    typedef enum logic [1:0] {
        KIND_LEN  = 2'd0,
        KIND_SEG  = 2'd1,
        KIND_ERR  = 2'd2,
        KIND_EOF  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  lines;
        logic [7:0]  bytes;
        logic [31:0] start;
    } seg_t;

    typedef struct packed {
        logic [NSLOTS-1:0] mask;
        logic [7:0]        hi_byte;
        logic [7:0]        lo_byte;
        seg_t              c1;
        seg_t              c2;
    } cmd_t;

endpackage

>>> hdl/llib_front.sv
module llib_front #(
    parameter int MAX_SEGMENT_BYTES = 150,
    parameter int MAX_SEGMENT_LINES = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    output logic             push,
    output llib_pkg::cmd_t   push_cmd,
    input  logic             full,
    output logic             halted
);
    import llib_pkg::*;

    localparam logic [7:0] MAX_B = 8'(MAX_SEGMENT_BYTES);
    localparam logic [7:0] MAX_L = 8'(MAX_SEGMENT_LINES);

    logic [14:0] ll_reg, ll_next;
    logic [7:0]  sb_reg, sb_next;
    logic [7:0]  ln_reg, ln_next;
    logic [31:0] lsp_reg, lsp_next;
    logic [31:0] ssp_reg, ssp_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [14:0] ll_inc;
    logic        too_long;
    logic        is_nl;
    logic        line_end;
    logic        hi;
    logic [7:0]  ll_quot;
    logic [31:0] lsp_sum;
    logic [7:0]  sb_inc;
    logic [7:0]  ln_inc;
    logic        seg_full;
    logic        close1;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    assign halted   = halted_reg;

    always_comb begin
        ll_inc   = ll_reg + 15'd1;
        too_long = ll_inc > LONGEST_LINE;
        is_nl    = s_tdata == NEWLINE;
        line_end = is_nl || s_tlast;
        hi       = ll_inc > SHORT_LINE_MAX;
        ll_quot  = ll_inc[14:7];
        lsp_sum  = lsp_reg + 32'(ll_inc);
        sb_inc   = sb_reg + (hi ? 8'd2 : 8'd1);
        ln_inc   = ln_reg + 8'd1;
        seg_full = (sb_inc >= MAX_B) || (ln_inc >= MAX_L);
        // a full segment at an unterminated last line closes only once, at eof
        close1   = seg_full && !(s_tlast && !is_nl);

        push_cmd          = '0;
        push_cmd.hi_byte  = 8'd0 - ll_quot;
        push_cmd.lo_byte  = {1'b0, ll_inc[6:0]};
        push_cmd.c1.lines = ln_inc;
        push_cmd.c1.bytes = sb_inc;
        push_cmd.c1.start = ssp_reg;
        push_cmd.c2.lines = close1 ? 8'd0 : ln_inc;
        push_cmd.c2.bytes = close1 ? 8'd0 : sb_inc;
        push_cmd.c2.start = close1 ? lsp_sum : ssp_reg;
        push = 1'b0;

        ll_next     = ll_reg;
        sb_next     = sb_reg;
        ln_next     = ln_reg;
        lsp_next    = lsp_reg;
        ssp_next    = ssp_reg;
        halted_next = halted_reg;

        if (accept && !halted_reg) begin
            if (too_long) begin
                push                      = 1'b1;
                push_cmd.mask[SLOT_ERR]   = 1'b1;
                halted_next               = 1'b1;
            end else if (line_end) begin
                push                      = 1'b1;
                push_cmd.mask[SLOT_HI]    = hi;
                push_cmd.mask[SLOT_LO]    = 1'b1;
                push_cmd.mask[SLOT_C1]    = close1;
                push_cmd.mask[SLOT_C2]    = s_tlast;
                push_cmd.mask[SLOT_TERM]  = s_tlast;
                ll_next  = '0;
                lsp_next = lsp_sum;
                if (close1 || s_tlast) begin
                    sb_next  = '0;
                    ln_next  = '0;
                    ssp_next = lsp_sum;
                end else begin
                    sb_next = sb_inc;
                    ln_next = ln_inc;
                end
            end else begin
                ll_next = ll_inc;
            end
        end

        // new start position
        if (cfg_wr_en) begin
            lsp_next = cfg_wr_data;
            ssp_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ll_reg     <= '0;
            sb_reg     <= '0;
            ln_reg     <= '0;
            lsp_reg    <= '0;
            ssp_reg    <= '0;
            halted_reg <= 1'b0;
        end else begin
            ll_reg     <= ll_next;
            sb_reg     <= sb_next;
            ln_reg     <= ln_next;
            lsp_reg    <= lsp_next;
            ssp_reg    <= ssp_next;
            halted_reg <= halted_next;
        end
    end

endmodule

>>> hdl/llib_queue.sv
module llib_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  llib_pkg::cmd_t  push_cmd,
    output logic            full,
    output logic            head_valid,
    output llib_pkg::cmd_t  head,
    input  logic            pop
);
    import llib_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/llib_back.sv
module llib_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  llib_pkg::cmd_t  head,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [55:0]     m_tdata,   // length_byte, segment_lines, segment_byte_count,
                                       // segment_start
    output logic [1:0]      m_tuser,   // kind
    output logic            m_tlast    // last_of_run
);
    import llib_pkg::*;

    logic [NSLOTS-1:0] done_reg, done_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [55:0]       m_tdata_reg, m_tdata_next;
    kind_t             kind_reg, kind_next;
    logic              m_tlast_reg, m_tlast_next;

    logic              load;
    logic              emit;
    logic [NSLOTS-1:0] pending;
    logic [NSLOTS-1:0] pick;
    logic [NSLOTS-1:0] rest;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        load    = !m_tvalid_reg || m_tready;
        emit    = load && head_valid;
        pending = head.mask & ~done_reg;
        pick    = pending & (~pending + NSLOTS'(1));
        rest    = pending & ~pick;
        pop     = emit && (rest == '0);

        done_next     = done_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        kind_next     = kind_reg;
        m_tlast_next  = m_tlast_reg;

        if (load) begin
            m_tvalid_next = emit;
        end
        if (emit) begin
            done_next    = (rest == '0) ? '0 : (done_reg | pick);
            m_tlast_next = rest == '0;
            m_tdata_next = '0;
            priority if (pick[SLOT_ERR]) begin
                kind_next = KIND_ERR;
            end else if (pick[SLOT_HI]) begin
                kind_next          = KIND_LEN;
                m_tdata_next[7:0]  = head.hi_byte;
            end else if (pick[SLOT_LO]) begin
                kind_next          = KIND_LEN;
                m_tdata_next[7:0]  = head.lo_byte;
            end else if (pick[SLOT_C1]) begin
                kind_next          = KIND_SEG;
                m_tdata_next[55:8] = {head.c1.start, head.c1.bytes, head.c1.lines};
            end else if (pick[SLOT_C2]) begin
                kind_next          = KIND_SEG;
                m_tdata_next[55:8] = {head.c2.start, head.c2.bytes, head.c2.lines};
            end else begin
                kind_next = KIND_EOF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        kind_reg    <= kind_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> hdl/line_length_index_builder_unit.sv
// Line length index builder.
// Input stream: one file byte per word on s_tdata[7:0]; s_tlast marks the final
// byte of the file. Result stream: m_tuser is the kind (length byte, segment
// closed, line too long, end-of-file terminator), m_tdata carries the length
// byte and the closed segment's line count, byte count and start position,
// m_tlast marks the last word caused by one input byte.
// cfg_wr_en / cfg_wr_data load the start position of the file; write it only
// while the block is idle. Counts are not touched by the write.
// Throughput: a byte that does not end a line is taken whenever s_tready is
// high. A byte that ends a line queues one command; the back end emits one word
// per cycle while m_tready is high, so a line costs one to five output words. A
// four-entry command queue between the front end and the output stage lets input
// run on while results drain. Results pass the queue, then the output register.
// Reset clears all counts, the start position and the halt flag. A stalled
// m_tready holds the output word; the queue fills and then s_tready drops.
// After a line too long the block halts: input bytes are taken and dropped
// until reset.
module line_length_index_builder_unit #(
    parameter int MAX_SEGMENT_BYTES = 150,
    parameter int MAX_SEGMENT_LINES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // length_byte, segment_lines, segment_byte_count,
                                   // segment_start
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import llib_pkg::*;

    logic  q_push;
    cmd_t  q_push_cmd;
    logic  q_full;
    logic  q_head_valid;
    cmd_t  q_head;
    logic  q_pop;
    logic  halted;

    llib_front #(
        .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES),
        .MAX_SEGMENT_LINES (MAX_SEGMENT_LINES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (q_push),
        .push_cmd    (q_push_cmd),
        .full        (q_full),
        .halted      (halted)
    );

    llib_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    llib_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // once halted, nothing more enters the queue
    a_halt_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        halted |-> !q_push)
        else $error("command queued while halted");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(halted) |-> halted)
        else $error("halt flag cleared without reset");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_ERR)) |-> m_tlast)
        else $error("error word not last of its run");

    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_EOF)) |-> m_tlast)
        else $error("terminator not last of its run");

endmodule
